### rtl/core/pn_pkg.sv
// Shared constants, types and arithmetic helpers for the octave Perlin noise block.
`default_nettype none
package pn_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int TABLE_SIZE  = 256;
  localparam int IDX_W       = 8;
  localparam int MAX_OCTAVES = 16;
  localparam int CNT_W       = 5;
  localparam int PERS_W      = 17;
  localparam int NOISE_W     = 18;
  localparam int QUO_W       = 24;

  // Configuration register indexes.
  localparam logic [1:0] REG_OCTAVES = 2'd0;
  localparam logic [1:0] REG_PERSIST = 2'd1;
  localparam logic [1:0] REG_UNIT    = 2'd2;

  // Operation codes of an input beat.
  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Steps of one octave.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_RD_X0  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_RD_X1  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_RD_H00 = 4'd2;
  localparam logic [STEP_W-1:0] STEP_RD_H01 = 4'd3;
  localparam logic [STEP_W-1:0] STEP_RD_H10 = 4'd4;
  localparam logic [STEP_W-1:0] STEP_RD_H11 = 4'd5;
  localparam logic [STEP_W-1:0] STEP_G11    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_LERP_X = 4'd7;
  localparam logic [STEP_W-1:0] STEP_LERP_Y = 4'd8;
  localparam logic [STEP_W-1:0] STEP_ACC    = 4'd9;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              start;
    logic              load;
    logic              oct_run;
    logic [STEP_W-1:0] step;
    logic              div_init;
    logic              div_run;
    logic              fin;
  } pn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CNT_W-1:0] oct_count;
  } pn_stat_t;

  // Corner gradient over four diagonal directions, chosen by three hash bits.
  function automatic logic signed [19:0] grad(input logic [2:0] h,
                                              input logic signed [17:0] dx,
                                              input logic signed [17:0] dy);
    logic signed [19:0] p;
    logic signed [19:0] q;
    begin
      p = h[2] ? 20'(dy) : 20'(dx);
      q = h[2] ? 20'(dx) : 20'(dy);
      if (h[0]) p = -p;
      if (h[1]) q = -q;
      grad = p + q;
    end
  endfunction

  // Linear blend a + floor(t * (b - a)).
  function automatic logic signed [23:0] lerp(input logic signed [17:0] t,
                                              input logic signed [23:0] a,
                                              input logic signed [23:0] b);
    logic signed [24:0] d;
    logic signed [42:0] pr;
    begin
      d = 25'(b) - 25'(a);
      pr = 43'(d) * 43'(t);
      lerp = a + $signed(pr[39:16]);
    end
  endfunction

endpackage
`default_nettype wire

### rtl/core/pn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/pn_ctrl.sv
// Controller state machine that sequences octaves, division and result delivery.
`default_nettype none
module pn_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic             in_op,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire pn_pkg::pn_stat_t stat,
  output pn_pkg::pn_cmd_t       cmd
);
  import pn_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_OCT  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  oct_r, oct_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    oct_nxt   = oct_r;
    cnt_nxt   = cnt_r;
    div_nxt   = div_r;
    cmd       = '0;
    cmd.step  = step_r;
    case (state_r)
      S_IDLE: begin
        cmd.load = accept && (in_op == OP_LOAD);
        if (accept && (in_op == OP_EVAL)) begin
          cmd.start = 1'b1;
          cnt_nxt   = stat.oct_count;
          oct_nxt   = '0;
          step_nxt  = '0;
          state_nxt = S_OCT;
        end
      end
      S_OCT: begin
        cmd.oct_run = 1'b1;
        if (step_r == STEP_ACC) begin
          step_nxt = '0;
          oct_nxt  = oct_r + 1'b1;
          if (oct_r == cnt_r - 1'b1) begin
            div_nxt   = '0;
            state_nxt = S_DIV;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_init = (div_r == '0);
        cmd.div_run  = (div_r != '0);
        div_nxt      = div_r + 1'b1;
        if (div_r == CNT_W'(QUO_W)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin = !out_valid_r || out_tready;
        if (cmd.fin) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result valid flag of the output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      oct_r       <= '0;
      cnt_r       <= '0;
      div_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      oct_r       <= oct_nxt;
      cnt_r       <= cnt_nxt;
      div_r       <= div_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted evaluate beat starts the octave sequence.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r == S_OCT))
    else $error("evaluate beat did not start the octave sequence");

  // Delivering a result always raises the output valid flag.
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_valid_r)
    else $error("result register not marked valid");

  // Octave index stays below the latched octave count.
  a_oct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OCT) |-> (oct_r < cnt_r) && (step_r <= STEP_ACC))
    else $error("octave sequencer out of range");

  // No beat is taken during the division phase.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> !cmd.start && !cmd.load)
    else $error("beat accepted while busy");

endmodule
`default_nettype wire

### rtl/core/pn_dp.sv
// Datapath: configuration, permutation table, fade, gradients, lerps, accumulation, divider.
`default_nettype none
module pn_dp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [16:0]           cfg_wdata,
  input  wire logic [79:0]           in_tdata,
  input  wire pn_pkg::pn_cmd_t       cmd,
  output pn_pkg::pn_stat_t           stat,
  output logic [23:0]                out_tdata
);
  import pn_pkg::*;

  // Configuration registers.
  logic [CNT_W-1:0]  cnt_cfg_r;
  logic [PERS_W-1:0] pers_cfg_r;
  logic              unit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_cfg_r  <= CNT_W'(1);
      pers_cfg_r <= PERS_W'(32768);
      unit_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OCTAVES: cnt_cfg_r  <= cfg_wdata[CNT_W-1:0];
        REG_PERSIST: pers_cfg_r <= cfg_wdata;
        REG_UNIT:    unit_r     <= cfg_wdata[0];
        default:     ;
      endcase
    end
  end

  // Octave count limited to the supported range.
  always_comb begin
    stat.oct_count = cnt_cfg_r;
    if (cnt_cfg_r == '0) begin
      stat.oct_count = CNT_W'(1);
    end else if (cnt_cfg_r > CNT_W'(MAX_OCTAVES)) begin
      stat.oct_count = CNT_W'(MAX_OCTAVES);
    end
  end

  // Permutation table: RAM plus per-entry valid bits; unwritten entries read as their index.
  logic [TABLE_SIZE-1:0] vld_r;
  logic [IDX_W-1:0]      raddr, raddr_q_r;
  logic                  vld_q_r;
  logic [IDX_W-1:0]      ram_rdata, perm;

  pn_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (in_tdata[71:64]),
    .wdata (in_tdata[79:72]),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.load) begin
      vld_r[in_tdata[71:64]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    raddr_q_r <= raddr;
    vld_q_r   <= vld_r[raddr];
  end

  assign perm = vld_q_r ? ram_rdata : raddr_q_r;

  // Point, amplitude and accumulator registers.
  logic [31:0]         x_r, y_r;
  logic [PERS_W-1:0]   pers_r, amp_r;
  logic [20:0]         max_amp_r;
  logic signed [31:0]  total_r;
  logic [IDX_W-1:0]    px0_r, px1_r;
  logic signed [19:0]  g00_r, g01_r, g10_r, g11_r;
  logic signed [23:0]  lo_r, hi_r, n_r;

  logic [15:0]         fx, fy;
  logic [IDX_W-1:0]    cx, cy;
  logic signed [17:0]  dx0, dx1, dy0, dy1;

  assign fx  = x_r[15:0];
  assign fy  = y_r[15:0];
  assign cx  = x_r[23:16];
  assign cy  = y_r[23:16];
  assign dx0 = $signed({2'b00, fx});
  assign dy0 = $signed({2'b00, fy});
  assign dx1 = dx0 - 18'sd65536;
  assign dy1 = dy0 - 18'sd65536;

  // Table read address per octave step.
  always_comb begin
    case (cmd.step)
      STEP_RD_X0:  raddr = cx;
      STEP_RD_X1:  raddr = cx + 1'b1;
      STEP_RD_H00: raddr = px0_r + cy;
      STEP_RD_H01: raddr = px0_r + cy + 1'b1;
      STEP_RD_H10: raddr = px1_r + cy;
      STEP_RD_H11: raddr = px1_r + cy + 1'b1;
      default:     raddr = cx;
    endcase
  end

  // Quintic fade for both axes, registered in stages.
  logic signed [23:0] m1x_r, m1y_r;
  logic [15:0]        sqx_r, sqy_r, cbx_r, cby_r;
  logic signed [17:0] u_r, v_r;
  logic signed [23:0] kx, ky, inx, iny;
  logic signed [40:0] pm1x, pm1y, pfx, pfy;
  logic [31:0]        psqx, psqy, pcbx, pcby;

  assign kx   = $signed(24'(fx) * 24'd6 - 24'd983040);
  assign ky   = $signed(24'(fy) * 24'd6 - 24'd983040);
  assign pm1x = $signed({25'd0, fx}) * 41'(kx);
  assign pm1y = $signed({25'd0, fy}) * 41'(ky);
  assign psqx = 32'(fx) * 32'(fx);
  assign psqy = 32'(fy) * 32'(fy);
  assign pcbx = 32'(sqx_r) * 32'(fx);
  assign pcby = 32'(sqy_r) * 32'(fy);
  assign inx  = m1x_r + 24'sd655360;
  assign iny  = m1y_r + 24'sd655360;
  assign pfx  = $signed({25'd0, cbx_r}) * 41'(inx);
  assign pfy  = $signed({25'd0, cby_r}) * 41'(iny);

  always_ff @(posedge clk) begin
    if (cmd.oct_run) begin
      case (cmd.step)
        STEP_RD_X0: begin
          m1x_r <= pm1x[39:16];
          m1y_r <= pm1y[39:16];
          sqx_r <= psqx[31:16];
          sqy_r <= psqy[31:16];
        end
        STEP_RD_X1: begin
          cbx_r <= pcbx[31:16];
          cby_r <= pcby[31:16];
        end
        STEP_RD_H00: begin
          u_r <= $signed(pfx[33:16]);
          v_r <= $signed(pfy[33:16]);
        end
        default: ;
      endcase
    end
  end

  // Hashes, corner gradients and blends.
  always_ff @(posedge clk) begin
    if (cmd.oct_run) begin
      case (cmd.step)
        STEP_RD_X1:  px0_r <= perm;
        STEP_RD_H00: px1_r <= perm;
        STEP_RD_H01: g00_r <= grad(perm[2:0], dx0, dy0);
        STEP_RD_H10: g01_r <= grad(perm[2:0], dx0, dy1);
        STEP_RD_H11: g10_r <= grad(perm[2:0], dx1, dy0);
        STEP_G11:    g11_r <= grad(perm[2:0], dx1, dy1);
        STEP_LERP_X: begin
          lo_r <= lerp(u_r, 24'(g00_r), 24'(g10_r));
          hi_r <= lerp(u_r, 24'(g01_r), 24'(g11_r));
        end
        STEP_LERP_Y: n_r <= lerp(v_r, lo_r, hi_r);
        default: ;
      endcase
    end
  end

  // Weighted accumulation, amplitude update and coordinate doubling.
  logic signed [41:0] pw;
  logic [33:0]        pa;

  assign pw = 42'(n_r) * $signed({25'd0, amp_r});
  assign pa = 34'(amp_r) * 34'(pers_r);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r       <= in_tdata[31:0];
      y_r       <= in_tdata[63:32];
      pers_r    <= (pers_cfg_r > PERS_W'(65536)) ? PERS_W'(65536) : pers_cfg_r;
      amp_r     <= PERS_W'(65536);
      max_amp_r <= '0;
      total_r   <= '0;
    end else if (cmd.oct_run && (cmd.step == STEP_ACC)) begin
      x_r       <= {x_r[30:0], 1'b0};
      y_r       <= {y_r[30:0], 1'b0};
      amp_r     <= pa[32:16];
      max_amp_r <= max_amp_r + 21'(amp_r);
      total_r   <= total_r + 32'($signed(pw[41:16]));
    end
  end

  // Restoring divider, one quotient bit per cycle, on the magnitude of the sum.
  logic [QUO_W-1:0] rem_r, dq_r;
  logic             neg_r;
  logic [31:0]      mag;
  logic [QUO_W:0]   trial;

  assign mag   = total_r[31] ? 32'(-total_r) : 32'(total_r);
  assign trial = {rem_r, dq_r[QUO_W-1]} - 25'(max_amp_r);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= mag[31:8];
      dq_r  <= {mag[7:0], 16'd0};
      neg_r <= total_r[31];
    end else if (cmd.div_run) begin
      if (!trial[QUO_W]) begin
        rem_r <= trial[QUO_W-1:0];
      end else begin
        rem_r <= {rem_r[QUO_W-2:0], dq_r[QUO_W-1]};
      end
      dq_r <= {dq_r[QUO_W-2:0], !trial[QUO_W]};
    end
  end

  // Floor sign fix, saturation, unit mapping and output register.
  logic signed [25:0]        qa, qn, qs, qu;
  logic [NOISE_W-1:0]        out_r;

  always_comb begin
    qa = $signed({2'b00, dq_r}) + 26'((neg_r && (rem_r != '0)) ? 1 : 0);
    qn = neg_r ? -qa : qa;
    qs = qn;
    if (qn > 26'sd65536) qs = 26'sd65536;
    if (qn < -26'sd65536) qs = -26'sd65536;
    qu = unit_r ? ((qs + 26'sd65536) >>> 1) : qs;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_r <= qu[NOISE_W-1:0];
    end
  end

  assign out_tdata = {6'd0, out_r};

endmodule
`default_nettype wire

### rtl/core/perlin_noise_2d_octaves.sv
// Top level of the fractal 2D improved Perlin noise block.
//
//  Channel | Direction | Beat contents
//  in_     | slave     | tuser: operation; tdata: x_coord, y_coord, entry_index, entry_value
//  out_    | master    | tdata: noise_value (18 bits, zero padded to 24)
//  cfg_    | write     | index 0 octave_count, 1 persistence, 2 unit_range_mode
//
// A load beat gives no result. An evaluate beat runs each octave as six
// serial reads of the permutation RAM, then blend and accumulate; then a
// divider setup step and 24 quotient bits of the one-bit-per-cycle divider,
// then the result goes into the output register once that register is free;
// the next beat is taken only after the result has been registered.
// Reset sets the table to identity through per-entry valid bits, with no clearing pass.
// A waiting result holds in the output register; loads are still taken meanwhile.
`default_nettype none
module perlin_noise_2d_octaves (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // x_coord[31:0], y_coord[63:32], entry_index[71:64],
                                       // entry_value[79:72]
  input  wire logic        in_tuser,   // operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // noise_value[17:0], zero padding above
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_wdata
);
  import pn_pkg::*;

  pn_cmd_t  cmd;
  pn_stat_t stat;

  pn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pn_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

endmodule
`default_nettype wire

### bench/perlin_noise_2d_octaves_tb.sv
// Self-checking testbench for the fractal 2D Perlin noise block, with a scoreboard.
module perlin_noise_2d_octaves_tb;
  import pn_pkg::*;

  localparam int ONE = 65536;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int PRESSURE_CYCLES = 1500;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_wdata = '0;

  perlin_noise_2d_octaves DUT (.*);

  always #5 clk = ~clk;

  // Shadow copy of the block state.
  logic [7:0]  perm_shadow [TABLE_SIZE];
  logic [4:0]  octaves_shadow;
  logic [16:0] persist_shadow;
  logic        unit_shadow;

  logic [17:0] noise_due [$];
  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  gaps_on = 1'b1;
  bit  stalls_on = 1'b1;
  int  pressure_req = 0;

  // Fixed point helpers, all floored to 16 fractional bits.
  function automatic longint fmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint fade(longint t);
    longint inner;
    inner = fmul(t, 6 * t - 15 * ONE) + 10 * ONE;
    return fmul(fmul(fmul(t, t), t), inner);
  endfunction

  function automatic longint mix(longint t, longint a, longint b);
    return a + fmul(t, b - a);
  endfunction

  function automatic longint slope(logic [7:0] h, longint dx, longint dy);
    longint p;
    longint q;
    p = h[2] ? dy : dx;
    q = h[2] ? dx : dy;
    if (h[0]) p = -p;
    if (h[1]) q = -q;
    return p + q;
  endfunction

  function automatic longint octave_noise(logic [31:0] xw, logic [31:0] yw);
    logic [7:0] cx;
    logic [7:0] cy;
    logic [7:0] px0;
    logic [7:0] px1;
    longint fx;
    longint fy;
    longint u;
    longint v;
    longint lo;
    longint hi;
    cx = xw[23:16];
    cy = yw[23:16];
    fx = longint'(xw[15:0]);
    fy = longint'(yw[15:0]);
    u = fade(fx);
    v = fade(fy);
    px0 = perm_shadow[cx];
    px1 = perm_shadow[8'(cx + 8'd1)];
    lo = mix(u, slope(perm_shadow[8'(px0 + cy)], fx, fy),
             slope(perm_shadow[8'(px1 + cy)], fx - ONE, fy));
    hi = mix(u, slope(perm_shadow[8'(px0 + cy + 8'd1)], fx, fy - ONE),
             slope(perm_shadow[8'(px1 + cy + 8'd1)], fx - ONE, fy - ONE));
    return mix(v, lo, hi);
  endfunction

  function automatic logic [17:0] predict_noise(logic [31:0] x, logic [31:0] y);
    int     count;
    longint pers;
    longint amp;
    longint total;
    longint amp_sum;
    longint n;
    count = int'(octaves_shadow);
    if (count == 0) count = 1;
    if (count > MAX_OCTAVES) count = MAX_OCTAVES;
    pers = longint'(persist_shadow);
    if (pers > ONE) pers = ONE;
    amp = ONE;
    total = 0;
    amp_sum = 0;
    for (int i = 0; i < count; i++) begin
      total += fmul(octave_noise(x << i, y << i), amp);
      amp_sum += amp;
      amp = fmul(amp, pers);
    end
    n = fdiv(total * ONE, amp_sum);
    if (n > ONE) n = ONE;
    if (n < -ONE) n = -ONE;
    if (unit_shadow) n = fdiv(n + ONE, 2);
    return n[17:0];
  endfunction

  // Sends one beat, waits for the handshake and records the prediction.
  task automatic send_beat(logic op, logic [31:0] x, logic [31:0] y,
                           logic [7:0] idx, logic [7:0] val);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {val, idx, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_LOAD) perm_shadow[idx] = val;
    else noise_due.push_back(predict_noise(x, y));
    gap = 0;
    if (gaps_on && $urandom_range(0, 9) >= 6)
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_eval(logic [31:0] x, logic [31:0] y);
    send_beat(OP_EVAL, x, y, 8'($urandom()), 8'($urandom()));
  endtask

  task automatic send_load(logic [7:0] idx, logic [7:0] val);
    send_beat(OP_LOAD, $urandom(), $urandom(), idx, val);
  endtask

  // Waits until every result is in, then lets a trailing load settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (noise_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OCTAVES: octaves_shadow = data[4:0];
      REG_PERSIST: persist_shadow = data;
      REG_UNIT:    unit_shadow    = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [4:0] oct, logic [16:0] pers, logic unit_mode);
    write_reg(REG_OCTAVES, 17'(oct));
    write_reg(REG_PERSIST, pers);
    write_reg(REG_UNIT, 17'(unit_mode));
  endtask

  // Random evaluate with coordinates that are wide or small.
  task automatic random_eval();
    logic [31:0] x;
    logic [31:0] y;
    x = $urandom();
    y = $urandom();
    if ($urandom_range(0, 2) == 0) begin
      x = 32'($signed(x) >>> $urandom_range(8, 20));
      y = 32'($signed(y) >>> $urandom_range(8, 20));
    end
    send_eval(x, y);
  endtask

  // Extreme coordinates and table entries at the default setting.
  task automatic test_directed_points();
    send_eval(32'h0000_0000, 32'h0000_0000);
    send_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_eval(32'h8000_0000, 32'h8000_0000);
    send_eval(32'hFFFF_FFFF, 32'h0000_8000);
    send_eval(32'h0000_FFFF, 32'hFFFF_0000);
    send_eval(32'h0001_8000, 32'hFFFE_4000);
    send_load(8'd0, 8'd255);
    send_load(8'd255, 8'd0);
    send_load(8'd1, 8'd7);
    send_eval(32'h0000_4000, 32'h00FF_C000);
    send_eval(32'hFF00_2000, 32'h0001_E000);
  endtask

  // Register extremes: zero and oversized octave counts, persistence limits, unit mode.
  task automatic test_register_extremes();
    configure(5'd0, 17'd0, 1'b0);
    send_eval(32'h1234_5678, 32'h9ABC_DEF0);
    configure(5'd31, 17'd131071, 1'b1);
    send_eval(32'h4000_0001, 32'hC000_0001);
    send_eval(32'h7FFF_FFFF, 32'h8000_0000);
    configure(5'd16, 17'd65536, 1'b0);
    send_eval(32'h0003_3333, 32'hFFFC_CCCD);
    send_eval(32'h8000_0000, 32'h7FFF_FFFF);
    configure(5'd17, 17'd1, 1'b1);
    send_eval(32'h0000_0000, 32'hFFFF_FFFF);
  endtask

  // Phases of random beats under varied register settings.
  task automatic test_random_phases();
    for (int phase = 0; phase < 10; phase++) begin
      gaps_on = (phase % 4 != 3);
      stalls_on = (phase % 4 != 2);
      configure((phase % 5 == 4) ? 5'd16 : 5'($urandom_range(0, 4)),
                ($urandom_range(0, 3) == 0) ? 17'($urandom_range(65536, 131071))
                                             : 17'($urandom_range(0, 65536)),
                1'($urandom_range(0, 1)));
      for (int k = 0; k < 125; k++) begin
        if ($urandom_range(0, 4) == 0) send_load(8'($urandom()), 8'($urandom()));
        else random_eval();
      end
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  // The receiver holds off while the sender keeps offering beats.
  task automatic test_backpressure();
    configure(5'd2, 17'd40000, 1'b0);
    pressure_req = PRESSURE_CYCLES;
    gaps_on = 1'b0;
    for (int k = 0; k < 40; k++) begin
      if (k % 4 == 1) send_load(8'($urandom()), 8'($urandom()));
      else random_eval();
    end
    gaps_on = 1'b1;
  endtask

  // Receiver readiness: random stalls, and one long hold-off when asked.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (pressure_req > 0) begin
      out_tready <= 1'b0;
      stall_left <= pressure_req;
      pressure_req = 0;
    end else if (stalls_on && $urandom_range(0, 9) < 3) begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                : $urandom_range(20, 80);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result check against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (noise_due.size() == 0) begin
        $error("unexpected result beat, noise_value actual %0d",
               $signed(out_tdata[17:0]));
        fail_count++;
      end else begin
        logic [17:0] want;
        want = noise_due.pop_front();
        if (out_tdata[17:0] !== want) begin
          $error("noise_value expected %0d actual %0d", $signed(want),
                 $signed(out_tdata[17:0]));
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat accepted on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < TABLE_SIZE; i++) perm_shadow[i] = 8'(i);
    octaves_shadow = 5'd1;
    persist_shadow = 17'd32768;
    unit_shadow    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_points();
    test_register_extremes();
    test_random_phases();
    test_backpressure();
    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && noise_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
